>>> rtl/core/flba_pkg.sv
// Shared types, codes and constants of the free-list block allocator.
`timescale 1ns / 1ps

package flba_pkg;

    // Default pool size.
    localparam int NBLOCKS_DEFAULT = 256;

    // Configuration port.
    localparam int  PADDR_W           = 3;
    localparam int  PDATA_W           = 32;
    localparam logic REG_POOL_COUNT   = 1'b0;
    localparam logic [8:0] POOL_COUNT_RESET = 9'd256;

    // Request actions.
    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_FREE    = 2'd1;
    localparam logic [1:0] ACT_REBUILD = 2'd2;
    localparam logic [1:0] ACT_INIT    = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_BADINDEX = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REBUILD,
        S_FINISH
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic latch;      // capture the request and read the head link
        logic commit_op;  // complete an allocate or a free
        logic rb_start;   // clear the rebuild walk index
        logic rb_step;    // write one link of the rebuilt list
        logic commit_rb;  // complete a rebuild or init
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_rebuild;
        logic count_zero;
        logic rb_last;
        logic slot_free;
    } ctrl_sts_t;

endpackage

>>> rtl/core/flba_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module flba_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/flba_ctrl.sv
// Sequencing state machine of the free-list block allocator.
`timescale 1ns / 1ps

module flba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  flba_pkg::ctrl_sts_t sts,
    output flba_pkg::ctrl_cmd_t cmd
);

    flba_pkg::state_t state_reg;
    flba_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= flba_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            flba_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = flba_pkg::S_EXEC;
                end
            end
            flba_pkg::S_EXEC:
            begin
                if (sts.is_rebuild)
                begin
                    state_next = sts.count_zero ? flba_pkg::S_FINISH : flba_pkg::S_REBUILD;
                end
                else if (sts.slot_free)
                begin
                    state_next = flba_pkg::S_IDLE;
                end
            end
            flba_pkg::S_REBUILD:
            begin
                if (sts.rb_last)
                begin
                    state_next = flba_pkg::S_FINISH;
                end
            end
            flba_pkg::S_FINISH:
            begin
                if (sts.slot_free)
                begin
                    state_next = flba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = flba_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            flba_pkg::S_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.latch = s_tvalid;
            end
            flba_pkg::S_EXEC:
            begin
                if (sts.is_rebuild)
                begin
                    cmd.rb_start = 1'b1;
                end
                else
                begin
                    cmd.commit_op = sts.slot_free;
                end
            end
            flba_pkg::S_REBUILD:
            begin
                cmd.rb_step = 1'b1;
            end
            flba_pkg::S_FINISH:
            begin
                cmd.commit_rb = sts.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/flba_dp.sv
// Datapath: list head, counters, link memory and result register.
`timescale 1ns / 1ps

module flba_dp #(
    parameter int NBLOCKS = flba_pkg::NBLOCKS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  flba_pkg::ctrl_cmd_t cmd,
    output flba_pkg::ctrl_sts_t sts,
    input  logic [1:0]          in_action,
    input  logic [7:0]          in_index,
    input  logic [8:0]          pool_count,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          out_status,
    output logic [7:0]          out_granted,
    output logic [8:0]          out_free,
    output logic [31:0]         out_alloc,
    output logic [31:0]         out_release
);

    localparam int IDX_W  = (NBLOCKS > 1) ? $clog2(NBLOCKS) : 1;
    localparam int LINK_W = $clog2(NBLOCKS + 1);
    localparam int CMP_W  = (LINK_W > 9) ? LINK_W : 9;
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NBLOCKS);
    localparam logic [CMP_W-1:0]  MAX_CMP   = CMP_W'(NBLOCKS);

    // Request held while it is worked on.
    logic [1:0]        action_reg;
    logic [7:0]        index_reg;

    logic [LINK_W-1:0] head_reg,    head_next;
    logic [LINK_W-1:0] free_reg,    free_next;
    logic [31:0]       alloc_reg,   alloc_next;
    logic [31:0]       rel_reg,     rel_next;
    logic [IDX_W-1:0]  rb_idx_reg,  rb_idx_next;
    logic              valid_reg,   valid_next;

    logic [1:0]        status_reg;
    logic [7:0]        granted_reg;
    logic [8:0]        free_out_reg;
    logic [31:0]       alloc_out_reg;
    logic [31:0]       rel_out_reg;

    logic [1:0]        status_c;
    logic [7:0]        granted_c;

    logic [CMP_W-1:0]  eff_count;
    logic [CMP_W-1:0]  rb_succ;
    logic              head_null;
    logic              idx_bad;
    logic              rb_last;
    logic              load_out;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [LINK_W-1:0] mem_wdata;
    logic              mem_re;
    logic [LINK_W-1:0] mem_rdata;
    logic [LINK_W-1:0] link_next;

    flba_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NBLOCKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (head_reg[IDX_W-1:0]),
        .rdata (mem_rdata)
    );

    // Effective count is the configured count clipped to the pool size.
    always_comb
    begin
        eff_count = (CMP_W'(pool_count) > MAX_CMP) ? MAX_CMP : CMP_W'(pool_count);
    end

    assign head_null = (head_reg >= NULL_LINK);
    assign idx_bad   = (CMP_W'(index_reg) >= eff_count);
    assign rb_succ   = CMP_W'(rb_idx_reg) + CMP_W'(1);
    assign rb_last   = (rb_succ >= eff_count);
    assign link_next = (mem_rdata >= NULL_LINK) ? NULL_LINK : mem_rdata;
    assign mem_re    = cmd.latch && !head_null;
    assign load_out  = cmd.commit_op || cmd.commit_rb;

    assign sts.is_rebuild = (action_reg == flba_pkg::ACT_REBUILD) ||
                            (action_reg == flba_pkg::ACT_INIT);
    assign sts.count_zero = (eff_count == '0);
    assign sts.rb_last    = rb_last;
    assign sts.slot_free  = !valid_reg || out_ready;

    always_comb
    begin
        head_next   = head_reg;
        free_next   = free_reg;
        alloc_next  = alloc_reg;
        rel_next    = rel_reg;
        rb_idx_next = rb_idx_reg;
        status_c    = flba_pkg::ST_OK;
        granted_c   = '0;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;

        if (cmd.commit_op)
        begin
            priority if (action_reg == flba_pkg::ACT_ALLOC)
            begin
                if (head_null)
                begin
                    status_c = flba_pkg::ST_EMPTY;
                end
                else
                begin
                    granted_c  = 8'(head_reg);
                    head_next  = link_next;
                    free_next  = (free_reg != '0) ? free_reg - LINK_W'(1) : free_reg;
                    alloc_next = alloc_reg + 32'd1;
                end
            end
            else
            begin
                if (idx_bad)
                begin
                    status_c = flba_pkg::ST_BADINDEX;
                end
                else
                begin
                    // Push: the freed block points at the old head.
                    mem_we    = 1'b1;
                    mem_waddr = IDX_W'(index_reg);
                    mem_wdata = head_reg;
                    head_next = LINK_W'(index_reg);
                    free_next = (free_reg < NULL_LINK) ? free_reg + LINK_W'(1) : free_reg;
                    rel_next  = rel_reg + 32'd1;
                end
            end
        end

        if (cmd.rb_start)
        begin
            rb_idx_next = '0;
        end

        if (cmd.rb_step)
        begin
            mem_we      = 1'b1;
            mem_waddr   = rb_idx_reg;
            mem_wdata   = rb_last ? NULL_LINK : LINK_W'(rb_succ);
            rb_idx_next = rb_idx_reg + IDX_W'(1);
        end

        if (cmd.commit_rb)
        begin
            head_next = (eff_count == '0) ? NULL_LINK : '0;
            free_next = LINK_W'(eff_count);
            if (action_reg == flba_pkg::ACT_INIT)
            begin
                alloc_next = '0;
                rel_next   = '0;
            end
        end
    end

    always_comb
    begin
        if (load_out)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= NULL_LINK;
            free_reg   <= '0;
            alloc_reg  <= '0;
            rel_reg    <= '0;
            rb_idx_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            free_reg   <= free_next;
            alloc_reg  <= alloc_next;
            rel_reg    <= rel_next;
            rb_idx_reg <= rb_idx_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            action_reg <= in_action;
            index_reg  <= in_index;
        end
        if (load_out)
        begin
            status_reg    <= status_c;
            granted_reg   <= granted_c;
            free_out_reg  <= 9'(free_next);
            alloc_out_reg <= alloc_next;
            rel_out_reg   <= rel_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_status  = status_reg;
    assign out_granted = granted_reg;
    assign out_free    = free_out_reg;
    assign out_alloc   = alloc_out_reg;
    assign out_release = rel_out_reg;

endmodule

>>> rtl/core/free_list_block_allocator.sv
// Top level of the free-list block allocator: request/result streams and register port.
`timescale 1ns / 1ps

// Buffer manager for a pool of NBLOCKS equal-sized blocks, named by index and
// kept on a last-in first-out free list whose links live in a link memory.
// Each request carries an action in s_tuser (allocate, free, rebuild, init) and
// a block index in s_tdata; each produces exactly one result with a status,
// the granted index, the free count and the two statistics counters. Allocate
// and free pass through S_IDLE, which accepts the request and reads the link at
// the list head, and S_EXEC, which updates the head and writes the link memory.
// Rebuild and init pass through S_IDLE (accept), S_EXEC (start the walk),
// S_REBUILD (skipped if count, the pool count register clipped to NBLOCKS, is
// zero; the single link memory write port relinks one block per cycle) and
// S_FINISH (set the head). The result sits in an output register, so the next
// request is accepted while a result still waits for m_tready; that request
// then holds until the result leaves. After reset the list is empty until a
// rebuild, init or free; the pool count (register 0, reset 256) should be written
// only while no request is in flight. There is no double-free check.

module free_list_block_allocator #(
    parameter int NBLOCKS = flba_pkg::NBLOCKS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,

    // Request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] block_index
    input  logic [1:0]                    s_tuser,   // [1:0] action

    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [87:0]                   m_tdata,   // [7:0] granted_index, [16:8] free_blocks,
                                                     // [48:17] alloc_total, [80:49] free_total
    output logic [1:0]                    m_tuser,   // [1:0] status

    // Register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [flba_pkg::PADDR_W-1:0]  paddr,
    input  logic [flba_pkg::PDATA_W-1:0]  pwdata,
    output logic [flba_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    flba_pkg::ctrl_cmd_t cmd;
    flba_pkg::ctrl_sts_t sts;

    logic [8:0]  pool_count_reg;
    logic [8:0]  pool_count_next;
    logic        reg_hit;

    logic [8:0]  res_free;
    logic [31:0] res_alloc;
    logic [31:0] res_release;
    logic [7:0]  res_granted;

    // Register port: word address in paddr[2], byte offset ignored.
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == flba_pkg::REG_POOL_COUNT);

    always_comb
    begin
        pool_count_next = pool_count_reg;
        if (psel && penable && pwrite && pready && reg_hit)
        begin
            pool_count_next = pwdata[8:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_count_reg <= flba_pkg::POOL_COUNT_RESET;
        end
        else
        begin
            pool_count_reg <= pool_count_next;
        end
    end

    assign prdata = reg_hit ? flba_pkg::PDATA_W'(pool_count_reg) : '0;

    // Sequencer: one request at a time.
    flba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // List state, link memory and result register.
    flba_dp #(
        .NBLOCKS (NBLOCKS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_action   (s_tuser),
        .in_index    (s_tdata),
        .pool_count  (pool_count_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (m_tuser),
        .out_granted (res_granted),
        .out_free    (res_free),
        .out_alloc   (res_alloc),
        .out_release (res_release)
    );

    // Pack the result fields, lowest first, padded to whole bytes.
    assign m_tdata = {7'd0, res_release, res_alloc, res_free, res_granted};

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the free-list block allocator: directed, saturation and random runs.
`timescale 1ns / 1ps

module testbench;

    localparam int POOL_MAX = flba_pkg::NBLOCKS_DEFAULT;
    localparam logic [8:0] NULL_LINK = 9'(POOL_MAX);
    localparam logic [flba_pkg::PADDR_W-1:0] POOL_SIZE_ADDR =
        flba_pkg::PADDR_W'(4 * flba_pkg::REG_POOL_COUNT);

    // One result as the block reports it.
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  granted;
        logic [8:0]  free_blocks;
        logic [31:0] alloc_total;
        logic [31:0] free_total;
    } result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [7:0]                    s_tdata;   // [7:0] block_index
    logic [1:0]                    s_tuser;   // [1:0] action
    logic                          m_tvalid;
    logic                          m_tready;
    logic [87:0]                   m_tdata;   // [7:0] granted_index, [16:8] free_blocks,
                                              // [48:17] alloc_total, [80:49] free_total
    logic [1:0]                    m_tuser;   // [1:0] status
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [flba_pkg::PADDR_W-1:0]  paddr;
    logic [flba_pkg::PDATA_W-1:0]  pwdata;
    logic [flba_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    free_list_block_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow copy of the allocator: link memory, list head, counters and
    // the configured pool size.
    logic [8:0]  chain_link [0:POOL_MAX-1];
    logic [8:0]  list_top;
    logic [8:0]  free_level;
    logic [31:0] grant_count;
    logic [31:0] return_count;
    logic [8:0]  pool_size;

    result_t pending_results [$];
    int      mismatches;
    int      result_no;
    bit      idle_on;   // allow random gaps and stalls
    bit      quiet;     // final stretch: no idling at all
    int      stall_left;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // Work out the result of one accepted request and advance the shadow state.
    function automatic result_t apply_request(input logic [1:0] act, input logic [7:0] idx);
        result_t     r;
        logic [8:0]  nxt;
        int unsigned span;
        r = '0;
        r.status = flba_pkg::ST_OK;
        span = (pool_size > POOL_MAX) ? POOL_MAX : pool_size;
        unique case (act)
            flba_pkg::ACT_ALLOC:
            begin
                if (list_top >= NULL_LINK)
                begin
                    r.status = flba_pkg::ST_EMPTY;
                end
                else
                begin
                    nxt = chain_link[list_top[7:0]];
                    r.granted = list_top[7:0];
                    // a link at or past the pool end terminates the list
                    list_top = (nxt >= NULL_LINK) ? NULL_LINK : nxt;
                    if (free_level > 0)
                        free_level = free_level - 1'b1;
                    grant_count = grant_count + 1;
                end
            end
            flba_pkg::ACT_FREE:
            begin
                if (idx >= span)
                begin
                    r.status = flba_pkg::ST_BADINDEX;
                end
                else
                begin
                    chain_link[idx] = list_top;
                    list_top = {1'b0, idx};
                    if (free_level < NULL_LINK)
                        free_level = free_level + 1'b1;
                    return_count = return_count + 1;
                end
            end
            default:
            begin
                // relink blocks in ascending order, block 0 on top
                for (int i = 0; i < span; i++)
                    chain_link[i] = (i + 1 < span) ? 9'(i + 1) : NULL_LINK;
                list_top = (span > 0) ? 9'd0 : NULL_LINK;
                free_level = 9'(span);
                if (act == flba_pkg::ACT_INIT)
                begin
                    grant_count = '0;
                    return_count = '0;
                end
            end
        endcase
        r.free_blocks = free_level;
        r.alloc_total = grant_count;
        r.free_total = return_count;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at result %0d: %s expected %0d got %0d",
                     result_no, what, want, got);
    endtask

    // Present one request, hold it until accepted, then record its prediction.
    // Returns in the time step of the accepting edge with tvalid still high, so
    // the caller must follow at once with another request or a drain.
    task automatic send_request(input logic [1:0] act, input logic [7:0] idx,
                                output result_t predicted);
        if (!quiet && idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= idx;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = apply_request(act, idx);
        pending_results.push_back(predicted);
    endtask

    // Drop the request stream and wait until every outstanding result is back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the pool size while the block is idle, then read it back.
    task automatic set_pool_size(input logic [8:0] value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= POOL_SIZE_ADDR;
        pwdata  <= flba_pkg::PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        pool_size = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== flba_pkg::PDATA_W'(value))
            note_mismatch("pool count read back", value, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: compare each result with the oldest prediction and drive
    // bursty back-pressure.
    initial
    begin : result_checker
        result_t want;
        result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                result_no++;
                got.status      = m_tuser;
                got.granted     = m_tdata[7:0];
                got.free_blocks = m_tdata[16:8];
                got.alloc_total = m_tdata[48:17];
                got.free_total  = m_tdata[80:49];
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with no request outstanding", result_no);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status)
                        note_mismatch("status", want.status, got.status);
                    if (got.granted !== want.granted)
                        note_mismatch("granted_index", want.granted, got.granted);
                    if (got.free_blocks !== want.free_blocks)
                        note_mismatch("free_blocks", want.free_blocks, got.free_blocks);
                    if (got.alloc_total !== want.alloc_total)
                        note_mismatch("alloc_total", want.alloc_total, got.alloc_total);
                    if (got.free_total !== want.free_total)
                        note_mismatch("free_total", want.free_total, got.free_total);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet && idle_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Extremes of each field, every action and the corner cases: use before
    // any rebuild, pushes onto an empty list, out-of-range frees, a count
    // changed without a rebuild, a zero count, an oversized count and the
    // free count clamped at the pool maximum.
    task automatic test_directed();
        result_t r;
        send_request(flba_pkg::ACT_ALLOC, 8'h00, r);     // nothing free after reset
        send_request(flba_pkg::ACT_FREE, 8'h00, r);      // push onto the empty list
        send_request(flba_pkg::ACT_FREE, 8'hFF, r);
        send_request(flba_pkg::ACT_ALLOC, 8'hFF, r);
        send_request(flba_pkg::ACT_ALLOC, 8'h5A, r);
        send_request(flba_pkg::ACT_ALLOC, 8'h00, r);     // list exhausted again
        set_pool_size(9'd5);
        send_request(flba_pkg::ACT_FREE, 8'h05, r);      // first index past the pool
        send_request(flba_pkg::ACT_FREE, 8'hFF, r);
        send_request(flba_pkg::ACT_FREE, 8'h04, r);
        send_request(flba_pkg::ACT_REBUILD, 8'hA5, r);
        send_request(flba_pkg::ACT_ALLOC, 8'h00, r);
        send_request(flba_pkg::ACT_INIT, 8'h00, r);
        set_pool_size(9'd2);                             // list kept, range check shrinks
        send_request(flba_pkg::ACT_FREE, 8'h03, r);
        send_request(flba_pkg::ACT_ALLOC, 8'h00, r);
        send_request(flba_pkg::ACT_ALLOC, 8'h00, r);
        send_request(flba_pkg::ACT_FREE, 8'h01, r);
        set_pool_size(9'd0);
        send_request(flba_pkg::ACT_REBUILD, 8'h00, r);   // empty pool
        send_request(flba_pkg::ACT_FREE, 8'h00, r);
        send_request(flba_pkg::ACT_ALLOC, 8'h00, r);
        set_pool_size(9'h1FF);                           // clipped to the pool maximum
        send_request(flba_pkg::ACT_REBUILD, 8'h00, r);
        send_request(flba_pkg::ACT_FREE, 8'hFF, r);      // double free, count clamps
        send_request(flba_pkg::ACT_ALLOC, 8'h00, r);
        send_request(flba_pkg::ACT_FREE, 8'hAA, r);
        set_pool_size(9'd256);
        send_request(flba_pkg::ACT_INIT, 8'h55, r);
    endtask

    // Overfill the list with repeated frees, then allocate past the point
    // where the free count bottoms out: allocation still follows the list.
    task automatic test_saturation();
        result_t r;
        set_pool_size(9'd256);
        send_request(flba_pkg::ACT_INIT, 8'($urandom), r);
        repeat (3)
            send_request(flba_pkg::ACT_FREE, 8'($urandom), r);
        repeat (262)
            send_request(flba_pkg::ACT_ALLOC, 8'($urandom), r);
    endtask

    // Mostly well-formed traffic: allocate, return blocks that are held,
    // with stray frees, double frees and the odd rebuild or init mixed in.
    task automatic test_random_traffic(input logic [8:0] count, input int items);
        logic [7:0] held [$];
        result_t    r;
        int         pick;
        int         pos;
        logic [7:0] idx;
        set_pool_size(count);
        send_request($urandom_range(0, 1) ? flba_pkg::ACT_INIT : flba_pkg::ACT_REBUILD,
                     8'($urandom), r);
        repeat (items)
        begin
            if ($urandom_range(0, 39) == 0)
                idle_on = !idle_on;
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                send_request(flba_pkg::ACT_ALLOC, 8'($urandom), r);
                if (r.status == flba_pkg::ST_OK)
                    held.push_back(r.granted);
            end
            else if (pick < 85 && held.size() != 0)
            begin
                pos = $urandom_range(0, held.size() - 1);
                idx = held[pos];
                held.delete(pos);
                send_request(flba_pkg::ACT_FREE, idx, r);
            end
            else if (pick < 95)
            begin
                send_request(flba_pkg::ACT_FREE, 8'($urandom), r);
            end
            else if (pick < 98)
            begin
                send_request(flba_pkg::ACT_REBUILD, 8'($urandom), r);
                held.delete();
            end
            else
            begin
                send_request(flba_pkg::ACT_INIT, 8'($urandom), r);
                held.delete();
            end
        end
    endtask

    initial
    begin
        mismatches = 0;
        result_no  = 0;
        idle_on    = 1'b1;
        quiet      = 1'b0;
        stall_left = 0;
        pool_size  = flba_pkg::POOL_COUNT_RESET;
        list_top     = NULL_LINK;
        free_level   = '0;
        grant_count  = '0;
        return_count = '0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= flba_pkg::ACT_ALLOC;
        m_tready <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_saturation();
        test_random_traffic(9'd1, 150);
        test_random_traffic(9'd2, 150);
        test_random_traffic(9'($urandom_range(3, 16)), 250);
        test_random_traffic(9'($urandom_range(17, 255)), 300);
        test_random_traffic(9'd256, 250);
        test_random_traffic(9'($urandom_range(1, 256)), 200);
        // last stretch at full rate on both sides
        drain_results();
        quiet = 1'b1;
        test_random_traffic(9'($urandom_range(1, 256)), 250);

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
